/* hw/rtl/aenc_pkg.sv */
// ----------------------------------------------------------------------------
// aenc_pkg: shared types and constants of the arithmetic encoder step unit
// Field widths, stream widths, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package aenc_pkg;

  localparam int unsigned DefPrecision = 32;
  localparam longint unsigned MaxTotal = 64'd65536;

  localparam int unsigned SymW    = 17;
  localparam int unsigned FollowW = 32;
  localparam logic [FollowW-1:0] FollowMax = '1;

  // stream widths: input is three symbol fields, output is bit and follow count
  localparam int unsigned STdataW = 56;
  localparam int unsigned MTdataW = 40;
  localparam int unsigned MTuserW = 3;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_RANGE  = 2'd1,
    STAT_FOLLOW_OVF = 2'd2,
    STAT_REFUSED    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_RENORM,
    S_CLOSE
  } state_e;

endpackage

/* hw/rtl/arithmetic_encoder_step_unit.sv */
// ----------------------------------------------------------------------------
// arithmetic_encoder_step_unit: binary arithmetic encoder with follow bits
// Narrows the code interval per symbol with a shared two-bit-per-cycle restoring divider,
// renormalizes one step per cycle unless the output stalls and streams one beat per bit
// (bitless if an item has none), with a sticky error on bad ranges and follow overflow.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata (low bit up)                  | tuser / tlast
//  ---------+-----------+-------------------------------------+---------------------------
//  s_axis   | in        | sym_low, sym_high, sym_total, zeros | tuser = mode
//  m_axis   | out       | out_bit, follow_count, zeros        | tuser = has_bit, status;
//           |           |                                     | tlast = last
//
// an encode item runs the two scaling divisions through the one divider, each a
// multiply step and divide steps over a QW-bit word, QW = PRECISION+1 rounded up
// to even, then the renormalization steps.
// finish, refused and bad-range items go from idle straight to the close state.
// s_axis_tready_o is high only while the sequencer is idle; a full output
// register with tready low stalls renormalization when a second bit is due.
// rst_ni clears the interval to full range, the follow count and error flags.

module arithmetic_encoder_step_unit
  import aenc_pkg::*;
#(
  parameter int unsigned PRECISION = DefPrecision
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [STdataW-1:0] s_axis_tdata_i,  // sym_low, sym_high, sym_total
  input  logic               s_axis_tuser_i,  // mode
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [MTdataW-1:0] m_axis_tdata_o,  // out_bit, follow_count
  output logic [MTuserW-1:0] m_axis_tuser_o,  // has_bit, status
  output logic               m_axis_tlast_o
);

  localparam int unsigned PW   = PRECISION;
  localparam int unsigned RW   = PW + 1;
  localparam int unsigned QW   = 2 * ((PW + 2) / 2);
  localparam int unsigned PRW  = RW + SymW;
  localparam int unsigned CntW = $clog2(QW / 2);
  localparam logic [PW-1:0] HalfC    = PW'(1) << (PW - 1);
  localparam logic [PW-1:0] QuarterC = PW'(1) << (PW - 2);

  state_e state_q, state_d;

  logic [PW-1:0]      low_q, low_d, high_q, high_d;
  logic [FollowW-1:0] pending_q, pending_d;
  logic               healthy_q, healthy_d, flushed_q, flushed_d;
  logic [SymW-1:0]    sl_q, sl_d, sh_q, sh_d, st_q, st_d;
  logic [RW-1:0]      range_q, range_d;
  logic               sel_q, sel_d;
  logic [SymW-1:0]    rem_q, rem_d;
  logic [QW-1:0]      num_q, num_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  status_e            status_q, status_d;
  logic               held_valid_q, held_valid_d, held_bit_q, held_bit_d;
  logic [FollowW-1:0] held_fc_q, held_fc_d;
  logic               out_valid_q, out_valid_d, out_has_q, out_has_d;
  logic               out_bit_q, out_bit_d, out_last_q, out_last_d;
  logic [FollowW-1:0] out_fc_q, out_fc_d;
  status_e            out_status_q, out_status_d;

  logic            in_acc, out_free;
  logic [SymW-1:0] in_low, in_high, in_total;
  logic            refuse, bad_range, follow_full;
  logic            rn_zero, rn_one, rn_mid, rn_emit, rn_stall;
  logic [PRW-1:0]  prod;
  logic [SymW:0]   trial1, trial2, rem1, rem2;
  logic            qb1, qb2;
  logic [QW-1:0]   num_next;
  logic [RW-1:0]   quo;
  logic [PW-1:0]   rn_low, rn_high;

  assign in_low   = s_axis_tdata_i[SymW-1:0];
  assign in_high  = s_axis_tdata_i[2*SymW-1:SymW];
  assign in_total = s_axis_tdata_i[3*SymW-1:2*SymW];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign refuse      = !healthy_q || flushed_q;
  assign follow_full = (pending_q == FollowMax);
  assign bad_range   = (in_total == '0) || (64'(in_total) > 64'(MaxTotal))
                    || (64'(in_total) > 64'(QuarterC)) || (in_low >= in_high)
                    || (in_high > in_total);

  // product of range and cumulative bound, split into remainder and shift word
  assign prod = PRW'(range_q) * PRW'(sel_q ? sl_q : sh_q);

  // two restoring division steps per cycle
  always_comb begin
    trial1   = {rem_q, num_q[QW-1]};
    qb1      = (trial1 >= {1'b0, st_q});
    rem1     = qb1 ? (trial1 - {1'b0, st_q}) : trial1;
    trial2   = {rem1[SymW-1:0], num_q[QW-2]};
    qb2      = (trial2 >= {1'b0, st_q});
    rem2     = qb2 ? (trial2 - {1'b0, st_q}) : trial2;
    num_next = {num_q[QW-3:0], qb1, qb2};
    quo      = num_next[RW-1:0];
  end

  // renormalization decode
  assign rn_zero  = !high_q[PW-1];
  assign rn_one   = high_q[PW-1] && low_q[PW-1];
  assign rn_mid   = high_q[PW-1] && !low_q[PW-1] && low_q[PW-2] && !high_q[PW-2];
  assign rn_emit  = rn_zero || rn_one;
  assign rn_stall = rn_emit && held_valid_q && !out_free;

  always_comb begin
    rn_low  = low_q;
    rn_high = high_q;
    if (rn_one) begin
      rn_low  = low_q - HalfC;
      rn_high = high_q - HalfC;
    end else if (rn_mid) begin
      rn_low  = low_q - QuarterC;
      rn_high = high_q - QuarterC;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (refuse || s_axis_tuser_i || bad_range) begin
            state_d = S_CLOSE;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == '0) begin
          state_d = sel_q ? S_RENORM : S_MUL;
        end
      end
      S_RENORM: begin
        if (rn_mid && follow_full) begin
          state_d = S_CLOSE;
        end else if (!rn_emit && !rn_mid) begin
          state_d = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    low_d        = low_q;
    high_d       = high_q;
    pending_d    = pending_q;
    healthy_d    = healthy_q;
    flushed_d    = flushed_q;
    sl_d         = sl_q;
    sh_d         = sh_q;
    st_d         = st_q;
    range_d      = range_q;
    sel_d        = sel_q;
    rem_d        = rem_q;
    num_d        = num_q;
    cnt_d        = cnt_q;
    status_d     = status_q;
    held_valid_d = held_valid_q;
    held_bit_d   = held_bit_q;
    held_fc_d    = held_fc_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_has_d    = out_has_q;
    out_bit_d    = out_bit_q;
    out_fc_d     = out_fc_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sl_d     = in_low;
          sh_d     = in_high;
          st_d     = in_total;
          sel_d    = 1'b0;
          range_d  = {1'b0, high_q} - {1'b0, low_q} + RW'(1);
          status_d = STAT_OK;
          if (refuse) begin
            healthy_d = 1'b0;
            status_d  = STAT_REFUSED;
          end else if (s_axis_tuser_i) begin
            if (follow_full) begin
              healthy_d = 1'b0;
              status_d  = STAT_FOLLOW_OVF;
            end else begin
              flushed_d    = 1'b1;
              held_valid_d = 1'b1;
              held_bit_d   = (low_q >= QuarterC);
              held_fc_d    = pending_q + FollowW'(1);
              pending_d    = '0;
            end
          end else if (bad_range) begin
            healthy_d = 1'b0;
            status_d  = STAT_BAD_RANGE;
          end
        end
      end
      S_MUL: begin
        rem_d = SymW'(prod >> QW);
        num_d = prod[QW-1:0];
        cnt_d = CntW'(QW / 2 - 1);
      end
      S_DIV: begin
        rem_d = rem2[SymW-1:0];
        num_d = num_next;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          if (!sel_q) begin
            high_d = PW'({1'b0, low_q} + quo - RW'(1));
            sel_d  = 1'b1;
          end else begin
            low_d = PW'({1'b0, low_q} + quo);
          end
        end
      end
      S_RENORM: begin
        if (rn_emit && !rn_stall) begin
          if (held_valid_q) begin
            out_valid_d  = 1'b1;
            out_has_d    = 1'b1;
            out_bit_d    = held_bit_q;
            out_fc_d     = held_fc_q;
            out_last_d   = 1'b0;
            out_status_d = STAT_OK;
          end
          held_valid_d = 1'b1;
          held_bit_d   = rn_one;
          held_fc_d    = pending_q;
          pending_d    = '0;
          low_d        = {rn_low[PW-2:0], 1'b0};
          high_d       = {rn_high[PW-2:0], 1'b1};
        end else if (rn_mid) begin
          if (follow_full) begin
            healthy_d = 1'b0;
            status_d  = STAT_FOLLOW_OVF;
          end else begin
            pending_d = pending_q + FollowW'(1);
            low_d     = {rn_low[PW-2:0], 1'b0};
            high_d    = {rn_high[PW-2:0], 1'b1};
          end
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_has_d    = held_valid_q;
          out_bit_d    = held_valid_q && held_bit_q;
          out_fc_d     = held_valid_q ? held_fc_q : '0;
          out_last_d   = 1'b1;
          out_status_d = status_q;
          held_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      low_q        <= '0;
      high_q       <= '1;
      pending_q    <= '0;
      healthy_q    <= 1'b1;
      flushed_q    <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      low_q        <= low_d;
      high_q       <= high_d;
      pending_q    <= pending_d;
      healthy_q    <= healthy_d;
      flushed_q    <= flushed_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sl_q         <= sl_d;
    sh_q         <= sh_d;
    st_q         <= st_d;
    range_q      <= range_d;
    sel_q        <= sel_d;
    rem_q        <= rem_d;
    num_q        <= num_d;
    cnt_q        <= cnt_d;
    status_q     <= status_d;
    held_bit_q   <= held_bit_d;
    held_fc_q    <= held_fc_d;
    out_has_q    <= out_has_d;
    out_bit_q    <= out_bit_d;
    out_fc_q     <= out_fc_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(MTdataW - FollowW - 1)'(0), out_fc_q, out_bit_q};
  assign m_axis_tuser_o  = {out_status_q, out_has_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* test/aenc_bit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aenc_bit_checker: beat predictor and comparator for the encoder step unit
// Watches both streams, runs its own copy of the encoder state for every
// accepted input beat, and compares each output beat against the oldest
// predicted code bit, field by field.
// ----------------------------------------------------------------------------

module aenc_bit_checker
  import aenc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  input  logic [STdataW-1:0] s_axis_tdata_i,  // sym_low, sym_high, sym_total
  input  logic               s_axis_tuser_i,  // mode
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  input  logic [MTdataW-1:0] m_axis_tdata_i,  // out_bit, follow_count
  input  logic [MTuserW-1:0] m_axis_tuser_i,  // has_bit, status
  input  logic               m_axis_tlast_i,
  output int                 mismatches_o,
  output int                 bits_owed_o
);

  localparam logic [63:0] CodeTop = (64'd1 << DefPrecision) - 64'd1;
  localparam logic [63:0] CodeHalf = 64'd1 << (DefPrecision - 1);
  localparam logic [63:0] CodeQuarter = 64'd1 << (DefPrecision - 2);
  localparam int unsigned MaxBeats = 32;

  typedef struct packed {
    logic               has_bit;
    logic               out_bit;
    logic [FollowW-1:0] follow_count;
    logic               last;
    status_e            status;
  } code_beat_t;

  // predicted encoder state
  logic [63:0]        code_low;
  logic [63:0]        code_high;
  logic [FollowW-1:0] follow_pend;
  bit                 healthy;
  bit                 flushed;

  code_beat_t bits_due[$];
  code_beat_t item_bits[$];

  // floor(span * v / t) split so the product stays small
  function automatic logic [63:0] share_of(logic [63:0] span, logic [63:0] v,
                                           logic [63:0] t);
    return (span / t) * v + ((span % t) * v) / t;
  endfunction

  function automatic void emit_bit(logic b);
    code_beat_t cb;
    if (item_bits.size() < MaxBeats) begin
      cb = '{has_bit: 1'b1, out_bit: b, follow_count: follow_pend, last: 1'b0,
             status: STAT_OK};
      item_bits.push_back(cb);
    end
    follow_pend = '0;
  endfunction

  task automatic encode_item(input logic mode, input logic [SymW-1:0] sl,
                             input logic [SymW-1:0] sh, input logic [SymW-1:0] st);
    status_e     outcome;
    logic [63:0] span;
    logic [63:0] lo_cut;
    logic [63:0] hi_cut;
    bit          settled;
    code_beat_t  cb;
    outcome = STAT_OK;
    item_bits.delete();
    if (!healthy || flushed) begin
      healthy = 1'b0;
      outcome = STAT_REFUSED;
    end else if (mode) begin
      if (follow_pend == FollowMax) begin
        healthy = 1'b0;
        outcome = STAT_FOLLOW_OVF;
      end else begin
        flushed = 1'b1;
        follow_pend = follow_pend + 1;
        emit_bit(code_low >= CodeQuarter);
      end
    end else if (st == 0 || st > MaxTotal || st > CodeQuarter || sl >= sh || sh > st) begin
      healthy = 1'b0;
      outcome = STAT_BAD_RANGE;
    end else begin
      span = code_high - code_low + 64'd1;
      hi_cut = share_of(span, 64'(sh), 64'(st));
      lo_cut = share_of(span, 64'(sl), 64'(st));
      code_high = code_low + hi_cut - 64'd1;
      code_low = code_low + lo_cut;
      settled = 1'b0;
      while (!settled) begin
        if (code_high < CodeHalf) begin
          emit_bit(1'b0);
        end else if (code_low >= CodeHalf) begin
          emit_bit(1'b1);
          code_low -= CodeHalf;
          code_high -= CodeHalf;
        end else if (code_low >= CodeQuarter && code_high < CodeHalf + CodeQuarter) begin
          if (follow_pend == FollowMax) begin
            healthy = 1'b0;
            outcome = STAT_FOLLOW_OVF;
            settled = 1'b1;
          end else begin
            follow_pend = follow_pend + 1;
            code_low -= CodeQuarter;
            code_high -= CodeQuarter;
          end
        end else begin
          settled = 1'b1;
        end
        if (!settled) begin
          code_low = (code_low << 1) & CodeTop;
          code_high = ((code_high << 1) | 64'd1) & CodeTop;
        end
      end
    end
    // an item without a code bit still answers with one bitless beat
    if (item_bits.size() == 0) begin
      cb = '{has_bit: 1'b0, out_bit: 1'b0, follow_count: '0, last: 1'b0,
             status: STAT_OK};
      item_bits.push_back(cb);
    end
    foreach (item_bits[k]) begin
      cb = item_bits[k];
      cb.last = (k == item_bits.size() - 1);
      cb.status = outcome;
      bits_due.push_back(cb);
    end
  endtask

  function automatic int field_diff(string name, longint unsigned want,
                                    longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    code_beat_t want;
    if (!rst_ni) begin
      code_low = '0;
      code_high = CodeTop;
      follow_pend = '0;
      healthy = 1'b1;
      flushed = 1'b0;
      bits_due.delete();
      mismatches_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (bits_due.size() == 0) begin
          $error("output beat with no code bit pending: tdata %h tuser %b",
                 m_axis_tdata_i, m_axis_tuser_i);
          mismatches_o++;
        end else begin
          want = bits_due.pop_front();
          mismatches_o += field_diff("has_bit", want.has_bit, m_axis_tuser_i[0]);
          mismatches_o += field_diff("out_bit", want.out_bit, m_axis_tdata_i[0]);
          mismatches_o += field_diff("follow_count", want.follow_count,
                                     m_axis_tdata_i[FollowW:1]);
          mismatches_o += field_diff("last", want.last, m_axis_tlast_i);
          mismatches_o += field_diff("status", want.status, m_axis_tuser_i[2:1]);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        encode_item(s_axis_tuser_i, s_axis_tdata_i[SymW-1:0],
                    s_axis_tdata_i[2*SymW-1:SymW], s_axis_tdata_i[3*SymW-1:2*SymW]);
      end
    end
    bits_owed_o = bits_due.size();
  end

endmodule

/* test/arithmetic_encoder_step_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arithmetic_encoder_step_unit_tb: stream test of the encoder step unit
// Feeds directed and random symbol ranges in bursts against a stalling sink,
// ends each run in one terminal case (flush or a bad range) followed by
// refused beats, and leaves the bit checking to the checker beside the unit.
// ----------------------------------------------------------------------------

module arithmetic_encoder_step_unit_tb;
  import aenc_pkg::*;

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_COIN,
    SINK_CHOKE,
    SINK_RHYTHM
  } sink_mode_e;

  localparam int unsigned SymMax = (1 << SymW) - 1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [STdataW-1:0] s_axis_tdata_i = '0;
  logic               s_axis_tuser_i = 1'b0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [MTdataW-1:0] m_axis_tdata_o;
  logic [MTuserW-1:0] m_axis_tuser_o;
  logic               m_axis_tlast_o;

  int  mismatches;
  int  bits_owed;
  logic s_fire = 1'b0;

  int unsigned burst_left = 0;
  int unsigned sink_left = 0;
  int unsigned sink_phase = 0;
  sink_mode_e  sink_mode = SINK_OPEN;

  arithmetic_encoder_step_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  aenc_bit_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .m_axis_tlast_i (m_axis_tlast_o),
    .mismatches_o   (mismatches),
    .bits_owed_o    (bits_owed)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) s_fire <= s_axis_tvalid_i && s_axis_tready_o;

  // sink backpressure, switching among four randomly chosen patterns
  always @(negedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(20, 300);
    end
    sink_left--;
    sink_phase++;
    case (sink_mode)
      SINK_OPEN:   m_axis_tready_i <= 1'b1;
      SINK_COIN:   m_axis_tready_i <= 1'($urandom_range(0, 1));
      SINK_CHOKE:  m_axis_tready_i <= ($urandom_range(0, 7) == 0);
      SINK_RHYTHM: m_axis_tready_i <= (sink_phase % 4 != 3);
      default:     m_axis_tready_i <= 1'b1;
    endcase
  end

  // called at a falling edge; returns at a falling edge once the beat is taken, after an idle gap when a burst ends
  task automatic send_item(input logic mode, input int unsigned lo, input int unsigned hi,
                           input int unsigned tot);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= mode;
    s_axis_tdata_i <= {5'd0, tot[SymW-1:0], hi[SymW-1:0], lo[SymW-1:0]};
    do @(negedge clk_i); while (!s_fire);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 8);
      gap = $urandom_range(1, 10);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_bits();
    s_axis_tvalid_i <= 1'b0;
    while (bits_owed != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned tot;
    int unsigned lo;
    int unsigned hi;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // full-range symbols narrow nothing and emit no bit
    send_item(1'b0, 0, 1, 1);
    send_item(1'b0, 0, 65536, 65536);
    // thinnest symbols at both ends of the largest model
    send_item(1'b0, 0, 1, 65536);
    send_item(1'b0, 65535, 65536, 65536);
    // middle third keeps the interval straddling: follow bits pile up
    send_item(1'b0, 1, 2, 3);
    send_item(1'b0, 1, 2, 3);
    send_item(1'b0, 1, 2, 3);
    send_item(1'b0, 0, 1, 2);
    send_item(1'b0, 1, 2, 3);
    send_item(1'b0, 1, 2, 2);
    send_item(1'b0, 32768, 32769, 65536);
    send_item(1'b0, 0, 65535, 65536);
    send_item(1'b0, 1, 65536, 65536);
    send_item(1'b0, 12345, 54321, 65536);
    send_item(1'b0, 21845, 43690, 65535);
    send_item(1'b0, 65534, 65535, 65535);
    drain_bits();

    for (int n = 0; n < 200; n++) begin
      case ($urandom_range(0, 3))
        0:       tot = 65536;
        1:       tot = $urandom_range(1, 65536);
        2:       tot = $urandom_range(1, 16);
        default: tot = 1 << $urandom_range(0, 16);
      endcase
      case ($urandom_range(0, 2))
        0: begin
          lo = $urandom_range(0, tot - 1);
          hi = $urandom_range(lo + 1, tot);
        end
        1: begin
          lo = $urandom_range(0, tot - 1);
          hi = lo + 1;
        end
        default: begin
          lo = 0;
          hi = $urandom_range(1, tot);
        end
      endcase
      send_item(1'b0, lo, hi, tot);
      if (n % 70 == 69) drain_bits();
    end

    // errors and the flush are sticky, so each run closes with one of them
    case ($urandom_range(0, 4))
      0: send_item(1'b1, $urandom_range(0, SymMax), $urandom_range(0, SymMax),
                   $urandom_range(0, SymMax));
      1: send_item(1'b0, 0, 1, 0);
      2: send_item(1'b0, 0, $urandom_range(1, 65536), $urandom_range(65537, SymMax));
      3: begin
        hi = $urandom_range(0, 65536);
        send_item(1'b0, $urandom_range(hi, SymMax), hi, 65536);
      end
      default: begin
        tot = $urandom_range(1, 65535);
        hi = $urandom_range(tot + 1, SymMax);
        send_item(1'b0, $urandom_range(0, hi - 1), hi, tot);
      end
    endcase
    // everything after the terminal beat is refused
    repeat (8) begin
      send_item(1'($urandom_range(0, 1)), $urandom_range(0, SymMax),
                $urandom_range(0, SymMax), $urandom_range(0, SymMax));
    end
    drain_bits();
    repeat (60) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/aenc_pkg.sv
hw/rtl/arithmetic_encoder_step_unit.sv
test/aenc_bit_checker.sv
test/arithmetic_encoder_step_unit_tb.sv
